// ----- hw/rtl/psc_pkg.sv -----
// psc_pkg: types, fixed-point constants and the shared q30 rounding helper
// for the polynomial sine/cosine pipeline. No dependencies.
package psc_pkg;

  // datapath widths
  localparam int unsigned X_W  = 32;  // q30 argument
  localparam int unsigned X2_W = 33;  // q30 square of the argument
  localparam int unsigned X3_W = 34;  // q30 cube of the argument
  localparam int unsigned K_W  = 32;  // horner partial sums
  localparam int unsigned V_W  = 36;  // polynomial results before clamping
  localparam int unsigned P_W  = 66;  // widest product

  // range reduction
  localparam logic signed [31:0] INV_2PI_Q32  = 32'sd683565276;
  localparam logic [31:0]        TWO_PI_FRAC  = 32'd2451551556;  // 2*pi*2^30 less 2^32
  localparam logic [31:0]        HALF_PI_Q30  = 32'd1686629713;
  localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
  localparam logic signed [63:0] QUARTER_TURN = 64'sd1073741824;

  // polynomial coefficients, q30
  localparam logic signed [K_W-1:0] COS_C0 = -32'sd1460530;
  localparam logic signed [K_W-1:0] COS_C1 = 32'sd44728536;
  localparam logic signed [K_W-1:0] COS_C2 = -32'sd536869862;
  localparam logic signed [K_W-1:0] SIN_C0 = -32'sd209458;
  localparam logic signed [K_W-1:0] SIN_C1 = 32'sd8946498;
  localparam logic signed [K_W-1:0] SIN_C2 = -32'sd178956818;
  localparam logic signed [V_W-1:0] ONE_Q30 = 36'sd1073741824;

  // reduced arguments for both outputs
  typedef struct packed {
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] xc;
  } psc_arg_t;

  // chosen argument, its square and the output routing
  typedef struct packed {
    logic signed [X_W-1:0]  x;
    logic signed [X2_W-1:0] x2;
    logic                   cneg;  // negate the cos form
    logic                   swap;  // sine takes the cos form
  } psc_sel_t;

  // both polynomial values with the output routing
  typedef struct packed {
    logic signed [V_W-1:0] sin_v;
    logic signed [V_W-1:0] cos_v;
    logic                  cneg;
    logic                  swap;
  } psc_val_t;

  // q30 product rounding, nearest with ties towards plus infinity
  function automatic logic signed [V_W-1:0] rnd_q30(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] r;
    r = v + P_W'(64'sd536870912);
    return V_W'(r >>> 30);
  endfunction

endpackage

// ----- hw/rtl/psc_reduce.sv -----
// psc_reduce: angle to turns, fold to a half turn and map to a q30 argument
// for sine and cosine, five register stages. Uses psc_pkg.
module psc_reduce #(
  parameter int unsigned ANGLE_FRAC_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [31:0]  angle_i,
  output logic                valid_o,
  input  logic                ready_i,
  output psc_pkg::psc_arg_t   arg_o
);
  import psc_pkg::*;

  localparam int unsigned NumStages = 5;

  logic [NumStages-1:0] vld_d, vld_q, rdy, en;

  assign rdy   = ~vld_q | {ready_i, rdy[NumStages-1:1]};
  assign en    = rdy & {vld_q[NumStages-2:0], valid_i};
  assign vld_d = (vld_q & ~rdy) | en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // |v| mod one turn, then distance from half a turn
  function automatic logic [31:0] fold_half(input logic neg, input logic [31:0] low);
    logic [31:0] m;
    m = neg ? (32'd0 - low) : low;
    return m[31] ? {1'b0, m[30:0]} : (HALF_TURN - m);
  endfunction

  // stage 1: angle times 1/(2*pi)
  logic signed [63:0] prod_d, prod_q;
  assign prod_d = 64'(angle_i) * 64'(INV_2PI_Q32);

  always_ff @(posedge clk_i) begin
    if (en[0]) prod_q <= prod_d;
  end

  // stage 2: turns for cosine, quarter turn minus that for sine
  logic signed [63:0] turns_c, turns_s;
  logic               neg_c_q, neg_s_q;
  logic [31:0]        low_c_q, low_s_q;
  assign turns_c = prod_q >>> ANGLE_FRAC_BITS;
  assign turns_s = QUARTER_TURN - turns_c;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      neg_c_q <= turns_c[63];
      low_c_q <= turns_c[31:0];
      neg_s_q <= turns_s[63];
      low_s_q <= turns_s[31:0];
    end
  end

  // stage 3: fold
  logic [31:0] u_s_d, u_c_d, u_s_q, u_c_q;
  assign u_s_d = fold_half(neg_s_q, low_s_q);
  assign u_c_d = fold_half(neg_c_q, low_c_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      u_s_q <= u_s_d;
      u_c_q <= u_c_d;
    end
  end

  // stage 4: fractional part of u * 2*pi; the 2^32 part is u itself
  logic [63:0] wp_s_d, wp_c_d, wp_s_q, wp_c_q;
  logic [31:0] u_s2_q, u_c2_q;
  assign wp_s_d = 64'(u_s_q) * 64'(TWO_PI_FRAC);
  assign wp_c_d = 64'(u_c_q) * 64'(TWO_PI_FRAC);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      wp_s_q <= wp_s_d;
      wp_c_q <= wp_c_d;
      u_s2_q <= u_s_q;
      u_c2_q <= u_c_q;
    end
  end

  // stage 5: argument in [-pi/2, pi/2], wraps into 32 bits
  psc_arg_t    arg_d, arg_q;
  logic [31:0] xs_sum, xc_sum;
  assign xs_sum = u_s2_q + wp_s_q[63:32] - HALF_PI_Q30;
  assign xc_sum = u_c2_q + wp_c_q[63:32] - HALF_PI_Q30;
  assign arg_d.xs = $signed(xs_sum);
  assign arg_d.xc = $signed(xc_sum);

  always_ff @(posedge clk_i) begin
    if (en[4]) arg_q <= arg_d;
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NumStages-1];
  assign arg_o   = arg_q;

endmodule

// ----- hw/rtl/psc_sqsel.sv -----
// psc_sqsel: squares of both arguments and choice of the smaller one,
// three register stages. Uses psc_pkg.
module psc_sqsel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  psc_pkg::psc_arg_t arg_i,
  output logic              valid_o,
  input  logic              ready_i,
  output psc_pkg::psc_sel_t sel_o
);
  import psc_pkg::*;

  localparam int unsigned NumStages = 3;

  logic [NumStages-1:0] vld_d, vld_q, rdy, en;

  assign rdy   = ~vld_q | {ready_i, rdy[NumStages-1:1]};
  assign en    = rdy & {vld_q[NumStages-2:0], valid_i};
  assign vld_d = (vld_q & ~rdy) | en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: raw squares
  logic signed [63:0] sq_s_d, sq_c_d, sq_s_q, sq_c_q;
  psc_arg_t           arg1_q;
  assign sq_s_d = 64'(arg_i.xs) * 64'(arg_i.xs);
  assign sq_c_d = 64'(arg_i.xc) * 64'(arg_i.xc);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sq_s_q <= sq_s_d;
      sq_c_q <= sq_c_d;
      arg1_q <= arg_i;
    end
  end

  // stage 2: rounded squares
  logic signed [X2_W-1:0] x2s_d, x2c_d, x2s_q, x2c_q;
  psc_arg_t               arg2_q;
  assign x2s_d = X2_W'(rnd_q30(P_W'(sq_s_q)));
  assign x2c_d = X2_W'(rnd_q30(P_W'(sq_c_q)));

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x2s_q  <= x2s_d;
      x2c_q  <= x2c_d;
      arg2_q <= arg1_q;
    end
  end

  // stage 3: the smaller square wins, sine argument on a tie
  psc_sel_t sel_d, sel_q;
  logic     use_s;
  assign use_s      = (x2c_q >= x2s_q);
  assign sel_d.x    = use_s ? arg2_q.xs : arg2_q.xc;
  assign sel_d.x2   = use_s ? x2s_q : x2c_q;
  assign sel_d.cneg = use_s ? arg2_q.xc[X_W-1] : arg2_q.xs[X_W-1];
  assign sel_d.swap = ~use_s;

  always_ff @(posedge clk_i) begin
    if (en[2]) sel_q <= sel_d;
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NumStages-1];
  assign sel_o   = sel_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (sel_q.x2 >= 0))
    else $error("selected square is negative");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[2] |=> ((sel_q.x2 == $past(x2s_q)) || (sel_q.x2 == $past(x2c_q))))
    else $error("selected square does not come from either argument");

endmodule

// ----- hw/rtl/psc_poly.sv -----
// psc_poly: horner evaluation of the sin and cos forms on the chosen
// argument, multiply and round in alternate stages, six stages. Uses psc_pkg.
module psc_poly (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  psc_pkg::psc_sel_t sel_i,
  output logic              valid_o,
  input  logic              ready_i,
  output psc_pkg::psc_val_t val_o
);
  import psc_pkg::*;

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] vld_d, vld_q, rdy, en;

  assign rdy   = ~vld_q | {ready_i, rdy[NumStages-1:1]};
  assign en    = rdy & {vld_q[NumStages-2:0], valid_i};
  assign vld_d = (vld_q & ~rdy) | en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: first coefficient products and the raw cube
  logic signed [64:0] m_s0_d, m_c0_d, m_x3_d, m_s0_q, m_c0_q, m_x3_q;
  psc_sel_t           sel1_q;
  assign m_s0_d = 65'(SIN_C0) * 65'(sel_i.x2);
  assign m_c0_d = 65'(COS_C0) * 65'(sel_i.x2);
  assign m_x3_d = 65'(sel_i.x) * 65'(sel_i.x2);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m_s0_q <= m_s0_d;
      m_c0_q <= m_c0_d;
      m_x3_q <= m_x3_d;
      sel1_q <= sel_i;
    end
  end

  // stage 2
  logic signed [K_W-1:0]  s1_d, c1_d, s1_q, c1_q;
  logic signed [X3_W-1:0] x3_d, x3_q;
  psc_sel_t               sel2_q;
  assign s1_d = K_W'(V_W'(SIN_C1) + rnd_q30(P_W'(m_s0_q)));
  assign c1_d = K_W'(V_W'(COS_C1) + rnd_q30(P_W'(m_c0_q)));
  assign x3_d = X3_W'(rnd_q30(P_W'(m_x3_q)));

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_q   <= s1_d;
      c1_q   <= c1_d;
      x3_q   <= x3_d;
      sel2_q <= sel1_q;
    end
  end

  // stage 3
  logic signed [64:0]     m_s1_d, m_c1_d, m_s1_q, m_c1_q;
  logic signed [X3_W-1:0] x3_3_q;
  psc_sel_t               sel3_q;
  assign m_s1_d = 65'(s1_q) * 65'(sel2_q.x2);
  assign m_c1_d = 65'(c1_q) * 65'(sel2_q.x2);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      m_s1_q <= m_s1_d;
      m_c1_q <= m_c1_d;
      x3_3_q <= x3_q;
      sel3_q <= sel2_q;
    end
  end

  // stage 4
  logic signed [K_W-1:0]  s2_d, c2_d, s2_q, c2_q;
  logic signed [X3_W-1:0] x3_4_q;
  psc_sel_t               sel4_q;
  assign s2_d = K_W'(V_W'(SIN_C2) + rnd_q30(P_W'(m_s1_q)));
  assign c2_d = K_W'(V_W'(COS_C2) + rnd_q30(P_W'(m_c1_q)));

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s2_q   <= s2_d;
      c2_q   <= c2_d;
      x3_4_q <= x3_3_q;
      sel4_q <= sel3_q;
    end
  end

  // stage 5: last products, by the cube for sin and the square for cos
  logic signed [P_W-1:0] m_s2_d, m_s2_q;
  logic signed [64:0]    m_c2_d, m_c2_q;
  psc_sel_t              sel5_q;
  assign m_s2_d = P_W'(s2_q) * P_W'(x3_4_q);
  assign m_c2_d = 65'(c2_q) * 65'(sel4_q.x2);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      m_s2_q <= m_s2_d;
      m_c2_q <= m_c2_d;
      sel5_q <= sel4_q;
    end
  end

  // stage 6
  psc_val_t val_d, val_q;
  assign val_d.sin_v = V_W'(sel5_q.x) + rnd_q30(m_s2_q);
  assign val_d.cos_v = ONE_Q30 + rnd_q30(P_W'(m_c2_q));
  assign val_d.cneg  = sel5_q.cneg;
  assign val_d.swap  = sel5_q.swap;

  always_ff @(posedge clk_i) begin
    if (en[5]) val_q <= val_d;
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NumStages-1];
  assign val_o   = val_q;

endmodule

// ----- hw/rtl/psc_output.sv -----
// psc_output: sign of the cos form, routing to sine and cosine, clamp and
// rounding to the output format, two stages. Uses psc_pkg.
module psc_output #(
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  psc_pkg::psc_val_t  val_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [31:0] sine_o,
  output logic signed [31:0] cosine_o
);
  import psc_pkg::*;

  localparam int unsigned NumStages = 2;
  localparam int          Shift     = 30 - int'(OUT_FRAC_BITS);
  localparam logic signed [31:0] RndHalf = 32'((Shift > 0) ? (1 << (Shift - 1)) : 0);

  logic [NumStages-1:0] vld_d, vld_q, rdy, en;

  assign rdy   = ~vld_q | {ready_i, rdy[NumStages-1:1]};
  assign en    = rdy & {vld_q[NumStages-2:0], valid_i};
  assign vld_d = (vld_q & ~rdy) | en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  function automatic logic signed [31:0] clamp_one(input logic signed [V_W-1:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'(ONE_Q30);
    end else if (v < -ONE_Q30) begin
      r = 32'(-ONE_Q30);
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // stage 1: sign, routing and clamp
  logic signed [V_W-1:0] cos_f, sine_pre, cosine_pre;
  logic signed [31:0]    sine_cl_d, cosine_cl_d, sine_cl_q, cosine_cl_q;
  assign cos_f       = val_i.cneg ? -val_i.cos_v : val_i.cos_v;
  assign sine_pre    = val_i.swap ? cos_f : val_i.sin_v;
  assign cosine_pre  = val_i.swap ? val_i.sin_v : cos_f;
  assign sine_cl_d   = clamp_one(sine_pre);
  assign cosine_cl_d = clamp_one(cosine_pre);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sine_cl_q   <= sine_cl_d;
      cosine_cl_q <= cosine_cl_d;
    end
  end

  // stage 2: round to nearest, ties up, into the output format
  logic signed [31:0] sine_d, cosine_d, sine_q, cosine_q;
  assign sine_d   = (sine_cl_q + RndHalf) >>> Shift;
  assign cosine_d = (cosine_cl_q + RndHalf) >>> Shift;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sine_q   <= sine_d;
      cosine_q <= cosine_d;
    end
  end

  assign ready_o  = rdy[0];
  assign valid_o  = vld_q[NumStages-1];
  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

endmodule

// ----- hw/rtl/poly_sine_cosine.sv -----
// poly_sine_cosine: sine and cosine of a fixed-point angle by range reduction
// and horner polynomials; uses psc_pkg, psc_reduce, psc_sqsel, psc_poly, psc_output.
// throughput one item per cycle while ready_i accepts each result, set by the sixteen-stage
// pipeline with valid bits.
// each stage takes a new item when empty or when it passes its item on.
// reset clears only the valid bits; the data registers are not reset.
module poly_sine_cosine #(
  parameter int unsigned ANGLE_FRAC_BITS = 24,
  parameter int unsigned OUT_FRAC_BITS   = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [31:0] angle_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [31:0] sine_o,
  output logic signed [31:0] cosine_o
);
  import psc_pkg::*;

  localparam logic signed [31:0] OutOne = 32'sd1 <<< OUT_FRAC_BITS;

  logic     arg_vld, arg_rdy, sel_vld, sel_rdy, val_vld, val_rdy;
  psc_arg_t arg;
  psc_sel_t sel;
  psc_val_t val;

  psc_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .angle_i (angle_i),
    .valid_o (arg_vld),
    .ready_i (arg_rdy),
    .arg_o   (arg)
  );

  psc_sqsel u_sqsel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (arg_vld),
    .ready_o (arg_rdy),
    .arg_i   (arg),
    .valid_o (sel_vld),
    .ready_i (sel_rdy),
    .sel_o   (sel)
  );

  psc_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_vld),
    .ready_o (sel_rdy),
    .sel_i   (sel),
    .valid_o (val_vld),
    .ready_i (val_rdy),
    .val_o   (val)
  );

  psc_output #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_output (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (val_vld),
    .ready_o  (val_rdy),
    .val_i    (val),
    .valid_o  (valid_o),
    .ready_i  (ready_i),
    .sine_o   (sine_o),
    .cosine_o (cosine_o)
  );

  // an empty output stage means every stage can take a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o)
    else $error("input stalled while the output stage is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((sine_o <= OutOne) && (sine_o >= -OutOne)))
    else $error("sine out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((cosine_o <= OutOne) && (cosine_o >= -OutOne)))
    else $error("cosine out of range");

endmodule
